/* rtl/lrf_pkg.sv */
// Shared types, codes and helpers for the RGBW fade engine.
// No dependencies.
package lrf_pkg;

  localparam int unsigned DefLedCount = 256;
  localparam int unsigned ChanW      = 16;
  localparam int unsigned ColW       = 4 * ChanW;
  localparam int unsigned BrtW       = 20;
  localparam int unsigned DvdW       = ChanW + BrtW;

  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_START  = 2'd1;
  localparam logic [1:0] ACT_RENDER = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam logic [2:0] WGT_W = 3'd5;
  localparam logic [2:0] WGT_R = 3'd3;
  localparam logic [2:0] WGT_G = 3'd4;
  localparam logic [2:0] WGT_B = 3'd2;

  typedef enum logic [1:0] {
    K_TICK,
    K_START,
    K_RENDER
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [7:0]        idx;
    logic [ColW-1:0]   target;
    logic [ChanW-1:0]  dur;
    logic              lim;
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_COPY,
    S_LD,
    S_BRT,
    S_LMUL,
    S_LGO,
    S_LDIV,
    S_BMUL,
    S_BSUM,
    S_BGO,
    S_BDIV,
    S_WB,
    S_OUT
  } state_t;

  // channel k: 0 = W (top), 3 = B (bottom)
  function automatic logic [ChanW-1:0] chan(input logic [ColW-1:0] c, input int unsigned k);
    chan = c[ColW-1-k*ChanW -: ChanW];
  endfunction

  function automatic logic [BrtW-1:0] bright(input logic [ColW-1:0] c);
    bright = BrtW'(WGT_W * chan(c, 0)) + BrtW'(WGT_R * chan(c, 1))
           + BrtW'(WGT_G * chan(c, 2)) + BrtW'(WGT_B * chan(c, 3));
  endfunction

  // floor(v/257): high byte, minus one when the low byte is below it
  function automatic logic [7:0] q257(input logic [ChanW-1:0] v);
    q257 = (v[7:0] < v[15:8]) ? v[15:8] - 8'd1 : v[15:8];
  endfunction

endpackage

/* rtl/lrf_front.sv */
// Front end: accepts input words, drops ignored ones, queues commands.
// Depends on lrf_pkg.
module lrf_front #(
  parameter int unsigned LED_COUNT = lrf_pkg::DefLedCount
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  output logic                       in_full,
  input  logic [1:0]                 in_action,
  input  logic [7:0]                 in_led_index,
  input  logic [15:0]                in_target_white,
  input  logic [15:0]                in_target_red,
  input  logic [15:0]                in_target_green,
  input  logic [15:0]                in_target_blue,
  input  logic [15:0]                in_duration_ticks,
  input  logic                       in_limit_brightness,
  output logic                       cmd_valid,
  output lrf_pkg::cmd_t              cmd,
  input  logic                       cmd_pop
);
  import lrf_pkg::*;

  cmd_t       q_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       acc, keep;
  cmd_t       cin;

  assign in_full   = (cnt_r == 2'd2);
  assign acc       = in_push && !in_full;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];

  always_comb begin
    cin.idx    = in_led_index;
    cin.target = {in_target_white, in_target_red, in_target_green, in_target_blue};
    cin.dur    = in_duration_ticks;
    cin.lim    = in_limit_brightness;
    cin.kind   = K_TICK;
    keep       = 1'b0;
    case (in_action)
      ACT_TICK: begin
        cin.kind = K_TICK;
        keep     = 1'b1;
      end
      ACT_START: begin
        cin.kind = K_START;
        keep     = 1'b1;
      end
      ACT_RENDER: begin
        cin.kind = K_RENDER;
        keep     = ({3'd0, in_led_index} < 11'(LED_COUNT));
      end
      default: keep = 1'b0;
    endcase
  end

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (acc && keep) begin
      wp_nxt = ~wp_r;
    end
    if (cmd_pop && cmd_valid) begin
      rp_nxt = ~rp_r;
    end
    cnt_nxt = cnt_r + {1'b0, acc && keep} - {1'b0, cmd_pop && cmd_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && keep) begin
      q_r[wp_r] <= cin;
    end
  end

endmodule

/* rtl/lrf_div.sv */
// Four-lane restoring divider, one quotient bit per cycle, 16-bit quotients.
// Depends on lrf_pkg.
module lrf_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          go,
  input  logic [3:0][lrf_pkg::DvdW-1:0] dvd,
  input  logic [lrf_pkg::BrtW-1:0]      dvs,
  output logic                          done,
  output logic [3:0][lrf_pkg::ChanW-1:0] quo
);
  import lrf_pkg::*;

  logic [3:0][BrtW-1:0]  rem_r;
  logic [3:0][ChanW-1:0] lo_r;
  logic [BrtW-1:0]       dvs_r;
  logic [4:0]            cnt_r;
  logic                  busy_r;
  logic                  done_r;
  logic [3:0][BrtW:0]    trial;
  logic [3:0]            ge;

  // done pulses in the same cycle that the last quotient bit lands in quo
  assign quo  = lo_r;
  assign done = done_r;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      trial[k] = {rem_r[k], lo_r[k][ChanW-1]};
      ge[k]    = (trial[k] >= {1'b0, dvs_r});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 5'd0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && !go && (cnt_r == 5'd1);
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd16;
      end else if (busy_r) begin
        cnt_r  <= cnt_r - 5'd1;
        busy_r <= (cnt_r != 5'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      dvs_r <= dvs;
      for (int k = 0; k < 4; k++) begin
        rem_r[k] <= dvd[k][DvdW-1:ChanW];
        lo_r[k]  <= dvd[k][ChanW-1:0];
      end
    end else if (busy_r) begin
      for (int k = 0; k < 4; k++) begin
        rem_r[k] <= ge[k] ? BrtW'(trial[k] - {1'b0, dvs_r}) : trial[k][BrtW-1:0];
        lo_r[k]  <= {lo_r[k][ChanW-2:0], ge[k]};
      end
    end
  end

endmodule

/* rtl/lrf_back.sv */
// Back end: fade state, colour stores, render sequencer and result register.
// Depends on lrf_pkg and lrf_div.
module lrf_back #(
  parameter int unsigned LED_COUNT = lrf_pkg::DefLedCount
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  input  lrf_pkg::cmd_t cmd,
  output logic          cmd_pop,
  output logic          out_empty,
  input  logic          out_pop,
  output logic [31:0]   out_led_word,
  output logic [7:0]    out_index
);
  import lrf_pkg::*;

  // only the first 256 LEDs can ever change; the rest stay zero forever
  localparam int unsigned ND = (LED_COUNT < 256) ? LED_COUNT : 256;
  localparam int unsigned AW = (ND > 1) ? $clog2(ND) : 1;
  localparam int unsigned CW = $clog2(ND + 1);

  state_t st_r, st_nxt;

  logic [ColW-1:0]  start_mem [ND];
  logic [ColW-1:0]  cur_mem   [ND];
  logic [ColW-1:0]  sq_r, cq_r;
  logic [ND-1:0]    cvld_r;

  logic [ColW-1:0]  target_r;
  logic             lim_r;
  logic [ChanW-1:0] dur_r, el_r;
  logic             active_r;

  logic [7:0]       idx_r;
  logic [CW-1:0]    cnt_r;
  logic [ColW-1:0]  s_r, end_r, col_r;
  logic [BrtW-1:0]  bs_r, bt_r;
  logic [3:0][DvdW-1:0]    prod_r;
  logic [3:0][2*ChanW-1:0] pa_r, pb_r;

  logic             out_vld_r;
  logic [31:0]      word_r;
  logic [7:0]       oidx_r;

  logic [AW-1:0]    rd_addr, cpy_wa, ridx;
  logic             cpy_we, cur_we, div_go, div_done, out_load;
  logic [BrtW-1:0]  div_dvs;
  logic [3:0][ChanW-1:0] quo;

  assign ridx      = idx_r[AW-1:0];
  assign cpy_wa    = AW'(cnt_r - CW'(1));
  assign out_empty = !out_vld_r;
  assign out_led_word = word_r;
  assign out_index    = oidx_r;
  // result register takes a new word when free or being emptied this cycle
  assign out_load  = (st_r == S_OUT) && (!out_vld_r || out_pop);

  lrf_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (div_go),
    .dvd  (prod_r),
    .dvs  (div_dvs),
    .done (div_done),
    .quo  (quo)
  );

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: begin
        if (cmd_valid) begin
          case (cmd.kind)
            K_START:  st_nxt = S_COPY;
            K_RENDER: st_nxt = S_LD;
            default:  st_nxt = S_IDLE;
          endcase
        end
      end
      S_COPY:  st_nxt = (cnt_r == CW'(ND)) ? S_IDLE : S_COPY;
      S_LD: begin
        if (!active_r)  st_nxt = S_OUT;
        else if (lim_r) st_nxt = S_BRT;
        else            st_nxt = S_BMUL;
      end
      S_BRT:   st_nxt = S_LMUL;
      S_LMUL:  st_nxt = (bs_r < bt_r) ? S_LGO : S_BMUL;
      S_LGO:   st_nxt = S_LDIV;
      S_LDIV:  st_nxt = div_done ? S_BMUL : S_LDIV;
      S_BMUL:  st_nxt = (el_r < dur_r) ? S_BSUM : S_WB;
      S_BSUM:  st_nxt = S_BGO;
      S_BGO:   st_nxt = S_BDIV;
      S_BDIV:  st_nxt = div_done ? S_WB : S_BDIV;
      S_WB:    st_nxt = S_OUT;
      S_OUT:   st_nxt = (!out_vld_r || out_pop) ? S_IDLE : S_OUT;
      default: st_nxt = S_IDLE;
    endcase
  end

  // control strobes
  always_comb begin
    cmd_pop = 1'b0;
    rd_addr = ridx;
    cpy_we  = 1'b0;
    cur_we  = 1'b0;
    div_go  = 1'b0;
    div_dvs = bt_r;
    case (st_r)
      S_IDLE: begin
        cmd_pop = cmd_valid;
        rd_addr = cmd.idx[AW-1:0];
      end
      S_COPY: begin
        rd_addr = cnt_r[AW-1:0];
        cpy_we  = (cnt_r != CW'(0));
      end
      S_LGO:   div_go = 1'b1;
      S_BGO: begin
        div_go  = 1'b1;
        div_dvs = BrtW'(dur_r);
      end
      S_BDIV:  div_dvs = BrtW'(dur_r);
      S_WB:    cur_we = 1'b1;
      default: cmd_pop = 1'b0;
    endcase
  end

  // never-rendered LEDs are copied as zero, so the start store needs no flags
  always_ff @(posedge clk) begin
    sq_r <= start_mem[rd_addr];
    cq_r <= cur_mem[rd_addr];
    if (cpy_we) begin
      start_mem[cpy_wa] <= cvld_r[cpy_wa] ? cq_r : '0;
    end
    if (cur_we) begin
      cur_mem[ridx] <= col_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      cvld_r    <= '0;
      target_r  <= '0;
      lim_r     <= 1'b0;
      dur_r     <= '0;
      el_r      <= '0;
      active_r  <= 1'b0;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      out_vld_r <= out_load || (out_vld_r && !out_pop);
      case (st_r)
        S_IDLE: begin
          if (cmd_valid) begin
            case (cmd.kind)
              K_TICK: begin
                if (el_r != '1) el_r <= el_r + ChanW'(1);
              end
              K_START: begin
                target_r <= cmd.target;
                dur_r    <= cmd.dur;
                lim_r    <= cmd.lim;
                el_r     <= '0;
                active_r <= 1'b1;
                cnt_r    <= '0;
              end
              default: cnt_r <= cnt_r;
            endcase
          end
        end
        S_COPY:  cnt_r <= cnt_r + CW'(1);
        S_WB:    cvld_r[ridx] <= 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  // render datapath
  always_ff @(posedge clk) begin
    case (st_r)
      S_IDLE: idx_r <= cmd.idx;
      S_LD: begin
        s_r   <= sq_r;
        col_r <= cvld_r[ridx] ? cq_r : '0;
        end_r <= target_r;
      end
      S_BRT: begin
        bs_r <= bright(s_r);
        bt_r <= bright(target_r);
      end
      S_LMUL: begin
        for (int k = 0; k < 4; k++) prod_r[k] <= DvdW'(chan(target_r, k) * bs_r);
      end
      S_LDIV: begin
        if (div_done) end_r <= {quo[0], quo[1], quo[2], quo[3]};
      end
      S_BMUL: begin
        col_r <= end_r;
        for (int k = 0; k < 4; k++) begin
          pa_r[k] <= chan(s_r, k) * (dur_r - el_r);
          pb_r[k] <= chan(end_r, k) * el_r;
        end
      end
      S_BSUM: begin
        for (int k = 0; k < 4; k++) prod_r[k] <= DvdW'(pa_r[k]) + DvdW'(pb_r[k]);
      end
      S_BDIV: begin
        if (div_done) col_r <= {quo[0], quo[1], quo[2], quo[3]};
      end
      S_OUT: begin
        if (out_load) begin
          word_r <= {q257(chan(col_r, 0)), q257(chan(col_r, 1)),
                     q257(chan(col_r, 2)), q257(chan(col_r, 3))};
          oidx_r <= idx_r;
        end
      end
      default: idx_r <= idx_r;
    endcase
  end

endmodule

/* rtl/led_rgbw_fade_engine.sv */
// RGBW linear crossfade engine, top level.
// Tick: handled in the back end's idle state. Render: straight from the load to the
// output when no fade has started, else up to two passes of the bit-serial divider.
// Start: a sweep copying the colour store (min(LED_COUNT,256) entries).
// Throughput: one item at a time in the back end; a two-word queue in front.
// A render also waits in its last state while the result register is still full.
// Reset (rst_n, synchronous): all colours, target, duration, elapsed read zero.
// Depends on lrf_pkg, lrf_front, lrf_back, lrf_div.
module led_rgbw_fade_engine #(
  parameter int unsigned LED_COUNT = lrf_pkg::DefLedCount
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_led_index,
  input  logic [15:0] in_target_white,
  input  logic [15:0] in_target_red,
  input  logic [15:0] in_target_green,
  input  logic [15:0] in_target_blue,
  input  logic [15:0] in_duration_ticks,
  input  logic        in_limit_brightness,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [31:0] out_led_word,
  output logic [7:0]  out_index
);
  import lrf_pkg::*;

  // command word between the front queue and the sequencer
  cmd_t cmd;
  logic cmd_valid, cmd_pop;

  // front: classifies words, drops unused action codes and out-of-range renders
  lrf_front #(.LED_COUNT(LED_COUNT)) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_action          (in_action),
    .in_led_index       (in_led_index),
    .in_target_white    (in_target_white),
    .in_target_red      (in_target_red),
    .in_target_green    (in_target_green),
    .in_target_blue     (in_target_blue),
    .in_duration_ticks  (in_duration_ticks),
    .in_limit_brightness(in_limit_brightness),
    .cmd_valid          (cmd_valid),
    .cmd                (cmd),
    .cmd_pop            (cmd_pop)
  );

  // back: stores, brightness limit, blend, quantize; holds one result word
  lrf_back #(.LED_COUNT(LED_COUNT)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_led_word(out_led_word),
    .out_index   (out_index)
  );

endmodule

/* sim/fade_checker.sv */
// Checker for the RGBW fade engine: watches both queue ports, predicts each
// rendered LED word and compares it. Depends on lrf_pkg.
`timescale 1ns / 100ps
module fade_checker #(
  parameter int unsigned LED_COUNT = lrf_pkg::DefLedCount
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic        in_full,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_led_index,
  input  logic [15:0] in_target_white,
  input  logic [15:0] in_target_red,
  input  logic [15:0] in_target_green,
  input  logic [15:0] in_target_blue,
  input  logic [15:0] in_duration_ticks,
  input  logic        in_limit_brightness,
  input  logic        out_empty,
  input  logic        out_pop,
  input  logic [31:0] out_led_word,
  input  logic [7:0]  out_index,
  output int          err_count,
  output int          words_pending
);
  import lrf_pkg::*;

  typedef struct packed {
    logic [31:0] word;
    logic [7:0]  idx;
  } led_word_t;

  logic [63:0] snap_col [LED_COUNT];
  logic [63:0] cur_col  [LED_COUNT];
  logic [63:0] tgt_col;
  logic        lim_on;
  logic [15:0] dur;
  logic [15:0] elapsed;
  logic        fading;
  led_word_t   word_q [$];

  assign words_pending = word_q.size();

  function automatic logic [63:0] weigh_sum(input logic [63:0] c);
    weigh_sum = 64'(5 * c[63:48]) + 64'(3 * c[47:32]) + 64'(4 * c[31:16]) + 64'(2 * c[15:0]);
  endfunction

  // end colour, scaled down to the start brightness when limiting
  function automatic logic [63:0] fade_end(input logic [63:0] s);
    logic [63:0] bt, bs, r;
    bt = weigh_sum(tgt_col);
    bs = weigh_sum(s);
    r = 0;
    if (!lim_on || bs >= bt) return tgt_col;
    for (int k = 0; k < 4; k++)
      r[63-16*k -: 16] = 16'((64'(tgt_col[63-16*k -: 16]) * bs) / bt);
    return r;
  endfunction

  task automatic predict_item(input logic [1:0] act, input logic [7:0] idx,
                              input logic [63:0] tgt, input logic [15:0] d,
                              input logic lim);
    logic [63:0] s, e, col;
    logic [63:0] acc;
    led_word_t w;
    case (act)
      ACT_TICK: if (elapsed != 16'hFFFF) elapsed++;
      ACT_START: begin
        for (int i = 0; i < LED_COUNT; i++) snap_col[i] = cur_col[i];
        tgt_col = tgt; dur = d; lim_on = lim; elapsed = 0; fading = 1;
      end
      ACT_RENDER: if (idx < LED_COUNT) begin
        if (fading) begin
          s = snap_col[idx];
          e = fade_end(s);
          if (elapsed < dur) begin
            for (int k = 0; k < 4; k++) begin
              acc = 64'(s[63-16*k -: 16]) * (dur - elapsed)
                  + 64'(e[63-16*k -: 16]) * elapsed;
              col[63-16*k -: 16] = 16'(acc / dur);
            end
          end else col = e;
          cur_col[idx] = col;
        end else col = cur_col[idx];
        for (int k = 0; k < 4; k++)
          w.word[31-8*k -: 8] = 8'(col[63-16*k -: 16] / 257);
        w.idx = idx;
        word_q.push_back(w);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    led_word_t x;
    if (!rst_n) begin
      for (int i = 0; i < LED_COUNT; i++) begin
        snap_col[i] = 0; cur_col[i] = 0;
      end
      tgt_col = 0; lim_on = 0; dur = 0; elapsed = 0; fading = 0;
      word_q.delete();
      err_count = 0;
    end else begin
      if (out_pop && !out_empty) begin
        if (word_q.size() == 0) begin
          $display("%0t: unexpected word idx=%0d word=%h", $time, out_index, out_led_word);
          err_count++;
        end else begin
          x = word_q.pop_front();
          if (x.word !== out_led_word) begin
            $display("%0t: led_word exp %h got %h", $time, x.word, out_led_word);
            err_count++;
          end
          if (x.idx !== out_index) begin
            $display("%0t: out_index exp %0d got %0d", $time, x.idx, out_index);
            err_count++;
          end
        end
      end
      if (in_push && !in_full)
        predict_item(in_action, in_led_index,
                     {in_target_white, in_target_red, in_target_green, in_target_blue},
                     in_duration_ticks, in_limit_brightness);
    end
  end
endmodule

/* sim/tb_top.sv */
// Testbench top for the RGBW fade engine: drives command words, pops LED
// words, and reports the verdict. Depends on lrf_pkg, fade_checker and the RTL.
`timescale 1ns / 100ps
module tb_top;
  import lrf_pkg::*;

  localparam int IdleLimit = 20000;  // well above the start sweep; plenty of margin

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic [1:0]  in_action;
  logic [7:0]  in_led_index;
  logic [15:0] in_target_white, in_target_red, in_target_green, in_target_blue;
  logic [15:0] in_duration_ticks;
  logic        in_limit_brightness;
  logic        out_empty;
  logic        out_pop;
  logic [31:0] out_led_word;
  logic [7:0]  out_index;
  int          err_count;
  int          words_pending;
  int          push_idle_pct;  // chance per cycle that the sender holds off
  int          pop_idle_pct;   // same for the receiver
  int          idle_cycles;

  led_rgbw_fade_engine uut (.*);
  fade_checker chk (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // receiver: pop at random, gated by the current idle rate
  always @(posedge clk) begin
    if (!rst_n) out_pop <= 0;
    else out_pop <= ($urandom_range(99) >= pop_idle_pct);
  end

  // watchdog: any cycle without an accepted word counts toward the limit
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // push one command word, holding it until accepted
  task automatic send_word(input logic [1:0] act, input logic [7:0] idx,
                           input logic [63:0] tgt, input logic [15:0] d,
                           input logic lim);
    while ($urandom_range(99) < push_idle_pct) begin
      in_push <= 0;
      @(posedge clk);
    end
    in_push <= 1;
    in_action <= act; in_led_index <= idx;
    {in_target_white, in_target_red, in_target_green, in_target_blue} <= tgt;
    in_duration_ticks <= d; in_limit_brightness <= lim;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  function automatic logic [15:0] rnd_chan();
    case ($urandom_range(3))
      0: rnd_chan = 16'h0000;
      1: rnd_chan = 16'hFFFF;
      default: rnd_chan = 16'($urandom);
    endcase
  endfunction

  // mostly small durations so fades complete; sometimes large or zero
  function automatic logic [15:0] rnd_dur();
    case ($urandom_range(9))
      0: rnd_dur = 0;
      1: rnd_dur = 16'($urandom);
      2: rnd_dur = 16'hFFFF;
      default: rnd_dur = 16'($urandom_range(1, 12));
    endcase
  endfunction

  task automatic random_item();
    int r;
    r = $urandom_range(99);
    if (r < 40) send_word(ACT_TICK, 8'($urandom), 64'({$urandom, $urandom}), 16'($urandom),
                          1'($urandom));
    else if (r < 47)
      send_word(ACT_START, 8'($urandom), {rnd_chan(), rnd_chan(), rnd_chan(), rnd_chan()},
                rnd_dur(), 1'($urandom));
    else if (r < 97)
      // favor a few LEDs so each one goes through several fades
      send_word(ACT_RENDER, ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(7)),
                64'({$urandom, $urandom}), 16'($urandom), 1'($urandom));
    else send_word(ACT_UNUSED, 8'($urandom), 64'({$urandom, $urandom}), 16'($urandom),
                   1'($urandom));
  endtask

  initial begin
    rst_n = 0;
    in_push = 0; in_action = ACT_TICK; in_led_index = 0;
    in_target_white = 0; in_target_red = 0; in_target_green = 0; in_target_blue = 0;
    in_duration_ticks = 0; in_limit_brightness = 0;
    push_idle_pct = 11; pop_idle_pct = 81;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: render before any fade, bad action, then fades
    send_word(ACT_RENDER, 8'd0, '0, 16'd0, 1'b0);
    send_word(ACT_RENDER, 8'd255, '1, 16'hFFFF, 1'b1);
    send_word(ACT_UNUSED, 8'd1, '1, 16'hFFFF, 1'b1);
    send_word(ACT_START, 8'd0, '1, 16'd0, 1'b0);        // zero duration: jump
    send_word(ACT_RENDER, 8'd0, '0, 16'd0, 1'b0);
    send_word(ACT_RENDER, 8'd255, '0, 16'd0, 1'b0);
    send_word(ACT_START, 8'd0, 64'h1234_8000_0101_FFFE, 16'd3, 1'b0);
    send_word(ACT_RENDER, 8'd0, '0, 16'd0, 1'b0);
    send_word(ACT_TICK, 8'd0, '0, 16'd0, 1'b0);
    send_word(ACT_RENDER, 8'd0, '0, 16'd0, 1'b0);
    send_word(ACT_TICK, 8'd0, '0, 16'd0, 1'b0);
    send_word(ACT_TICK, 8'd0, '0, 16'd0, 1'b0);
    send_word(ACT_RENDER, 8'd0, '0, 16'd0, 1'b0);
    send_word(ACT_START, 8'd0, '1, 16'd2, 1'b1);        // limited: brightness capped
    send_word(ACT_TICK, 8'd0, '0, 16'd0, 1'b0);
    send_word(ACT_RENDER, 8'd0, '0, 16'd0, 1'b0);
    send_word(ACT_RENDER, 8'd7, '0, 16'd0, 1'b0);
    send_word(ACT_START, 8'd0, 64'h0000_0000_0000_0001, 16'hFFFF, 1'b1);
    send_word(ACT_RENDER, 8'd0, '0, 16'd0, 1'b0);
    send_word(ACT_START, 8'd0, 64'h0101_0202_0303_0404, 16'd1, 1'b0);
    send_word(ACT_RENDER, 8'd0, '0, 16'd0, 1'b0);

    for (int ph = 0; ph < 3; ph++) begin
      push_idle_pct = (ph == 0) ? 11 : (ph == 1) ? 81 : 0;
      pop_idle_pct  = (ph == 0) ? 81 : (ph == 1) ? 11 : 0;
      repeat (410) random_item();
    end
    in_push <= 0;

    while (words_pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (err_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

/* sim.f */
rtl/lrf_pkg.sv
rtl/lrf_front.sv
rtl/lrf_div.sv
rtl/lrf_back.sv
rtl/led_rgbw_fade_engine.sv
sim/fade_checker.sv
sim/tb_top.sv
